[src/mdu_pkg.sv]
// Shared types and constants for the Minkowski distance unit.
package mdu_pkg;

    localparam int SUM_WIDTH  = 64;
    localparam int MAG_WIDTH  = 16;
    localparam int ROOT_WIDTH = 32;
    localparam int BIT_WIDTH  = 5;

    typedef logic [2:0]           t_order;
    typedef logic [SUM_WIDTH-1:0] t_sum;

    localparam t_order ORD_MANHATTAN = 3'd1;
    localparam t_order ORD_EUCLID    = 3'd2;
    localparam t_order ORD_CUBIC     = 3'd3;
    localparam t_order ORD_QUARTIC   = 3'd4;
    localparam t_order ORD_RESET     = ORD_EUCLID;

    localparam logic [BIT_WIDTH-1:0] ROOT_TOP_SQUARE  = 5'd31;
    localparam logic [BIT_WIDTH-1:0] ROOT_TOP_CUBE    = 5'd21;
    localparam logic [BIT_WIDTH-1:0] ROOT_TOP_QUARTIC = 5'd15;

    typedef struct packed {
        t_sum   sum;
        logic   sat;
        t_order ord;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_RAISE,
        ST_TEST,
        ST_DONE
    } t_root_state;

    typedef struct packed {
        logic pop;
        logic square;
        logic raise;
        logic test;
        logic load_out;
    } t_root_ctl;

    function automatic logic [BIT_WIDTH-1:0] root_top(t_order ord);
        logic [BIT_WIDTH-1:0] top;
        case (ord)
            ORD_CUBIC:   top = ROOT_TOP_CUBE;
            ORD_QUARTIC: top = ROOT_TOP_QUARTIC;
            default:     top = ROOT_TOP_SQUARE;
        endcase
        return top;
    endfunction

endpackage

[src/minkowski_distance_unit.sv]
// Top level of the Minkowski distance unit.
// Takes one element pair per cycle while the queue has room. Each pair adds
// |a-b|^p to a saturating 64-bit sum through a four-stage power pipeline; the
// last pair of a vector hands the sum to a two-entry queue and clears it. The
// root engine then takes the sum and works out floor(sum^(1/p)) one bit per
// step: p = 1 passes the sum straight through, p = 2 takes 32 steps, p = 3
// takes 22 steps and p = 4 takes 16 steps. Vectors shorter than the root
// time of the vector ahead fill the queue and then hold i_valid off with
// o_stall. A write to the order register takes effect for pairs
// transferred after it.
module minkowski_distance_unit #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int MAX_ORDER     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_power_order_we,
    input  logic [2:0]  i_power_order,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_first_element,
    input  logic [15:0] i_second_element,
    input  logic        i_last_pair,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_distance,
    output logic        o_overflowed
);

    logic          push;
    logic          full;
    logic          q_valid;
    logic          pop;
    mdu_pkg::t_job push_job;
    mdu_pkg::t_job pop_job;

    mdu_front #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .MAX_ORDER     (MAX_ORDER)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_power_order_we (i_power_order_we),
        .i_power_order    (i_power_order),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_element  (i_first_element),
        .i_second_element (i_second_element),
        .i_last_pair      (i_last_pair),
        .i_full           (full),
        .o_push           (push),
        .o_job            (push_job)
    );

    mdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (pop_job)
    );

    mdu_root u_root (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (pop_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_distance   (o_distance),
        .o_overflowed (o_overflowed)
    );

endmodule

[src/mdu_front.sv]
// Front end: pair intake, power pipeline and saturating power sum.
module mdu_front #(
    parameter int ELEMENT_WIDTH = 16,
    parameter int MAX_ORDER     = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_power_order_we,
    input  logic [2:0]            i_power_order,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_first_element,
    input  logic [15:0]           i_second_element,
    input  logic                  i_last_pair,
    input  logic                  i_full,
    output logic                  o_push,
    output mdu_pkg::t_job         o_job
);

    localparam int DIFF_WIDTH = 17;

    mdu_pkg::t_order                  r_power_order;
    mdu_pkg::t_order                  eff_order;

    logic signed [DIFF_WIDTH-1:0]     a_ext;
    logic signed [DIFF_WIDTH-1:0]     b_ext;
    logic signed [DIFF_WIDTH-1:0]     diff;
    logic        [DIFF_WIDTH-1:0]     mag_full;
    logic                             advance;
    logic                             accept;

    logic                             r_a_v;
    logic [mdu_pkg::MAG_WIDTH-1:0]    r_a_mag;
    mdu_pkg::t_order                  r_a_ord;
    logic                             r_a_last;

    logic                             r_b_v;
    logic [mdu_pkg::MAG_WIDTH-1:0]    r_b_mag;
    logic [2*mdu_pkg::MAG_WIDTH-1:0]  r_b_sq;
    mdu_pkg::t_order                  r_b_ord;
    logic                             r_b_last;

    logic                             r_c_v;
    mdu_pkg::t_sum                    r_c_term;
    mdu_pkg::t_order                  r_c_ord;
    logic                             r_c_last;

    mdu_pkg::t_sum                    r_sum;
    logic                             r_sat;
    mdu_pkg::t_sum                    n_sum;
    logic                             n_sat;

    logic [2*mdu_pkg::MAG_WIDTH-1:0]  mag_sq;
    logic [3*mdu_pkg::MAG_WIDTH-1:0]  mag_cube;
    mdu_pkg::t_sum                    mag_quartic;
    mdu_pkg::t_sum                    term;
    logic [mdu_pkg::SUM_WIDTH:0]      sum_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power_order <= mdu_pkg::ORD_RESET;
        end else if (i_power_order_we) begin
            r_power_order <= i_power_order;
        end
    end

    always_comb begin
        if (r_power_order < mdu_pkg::ORD_MANHATTAN) begin
            eff_order = mdu_pkg::ORD_MANHATTAN;
        end else if (r_power_order > 3'(MAX_ORDER)) begin
            eff_order = 3'(MAX_ORDER);
        end else begin
            eff_order = r_power_order;
        end
    end

    assign a_ext    = DIFF_WIDTH'(signed'(i_first_element[ELEMENT_WIDTH-1:0]));
    assign b_ext    = DIFF_WIDTH'(signed'(i_second_element[ELEMENT_WIDTH-1:0]));
    assign diff     = a_ext - b_ext;
    assign mag_full = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);

    // hold the whole pipe while a finished sum cannot enter the queue
    assign advance = !(r_c_v && r_c_last && i_full);
    assign o_stall = !advance;
    assign accept  = i_valid && advance;

    assign mag_sq      = r_a_mag * r_a_mag;
    assign mag_cube    = r_b_sq * r_b_mag;
    assign mag_quartic = r_b_sq * r_b_sq;

    always_comb begin
        case (r_b_ord)
            mdu_pkg::ORD_MANHATTAN: term = mdu_pkg::SUM_WIDTH'(r_b_mag);
            mdu_pkg::ORD_EUCLID:    term = mdu_pkg::SUM_WIDTH'(r_b_sq);
            mdu_pkg::ORD_CUBIC:     term = mdu_pkg::SUM_WIDTH'(mag_cube);
            default:                term = mag_quartic;
        endcase
    end

    assign sum_wide = {1'b0, r_sum} + {1'b0, r_c_term};

    always_comb begin
        if (sum_wide[mdu_pkg::SUM_WIDTH]) begin
            n_sum = '1;
            n_sat = 1'b1;
        end else begin
            n_sum = sum_wide[mdu_pkg::SUM_WIDTH-1:0];
            n_sat = r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (advance) begin
            r_a_v <= accept;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            if (r_c_v) begin
                if (r_c_last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_sat <= n_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_mag  <= mag_full[mdu_pkg::MAG_WIDTH-1:0];
            r_a_ord  <= eff_order;
            r_a_last <= i_last_pair;
            r_b_mag  <= r_a_mag;
            r_b_sq   <= mag_sq;
            r_b_ord  <= r_a_ord;
            r_b_last <= r_a_last;
            r_c_term <= term;
            r_c_ord  <= r_b_ord;
            r_c_last <= r_b_last;
        end
    end

    assign o_push    = advance && r_c_v && r_c_last;
    assign o_job.sum = n_sum;
    assign o_job.sat = n_sat;
    assign o_job.ord = r_c_ord;

`ifndef ASSERT_OFF
    a_sat_sticks_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_sum == '1))
        else $error("saturation flag set with sum below full scale");
`endif

endmodule

[src/mdu_queue.sv]
// Two-entry queue of finished power sums between front and root engine.
module mdu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mdu_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output mdu_pkg::t_job o_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    mdu_pkg::t_job      r_entry [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_entry[r_rd_ptr];

`ifndef ASSERT_OFF
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(r_count == '0) && !(r_count > (PTR_W+1)'(DEPTH)))
        else $error("queue count left its range");
`endif

endmodule

[src/mdu_root.sv]
// Back end: bit-by-bit integer p-th root and result register.
module mdu_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  mdu_pkg::t_job               i_job,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [mdu_pkg::SUM_WIDTH-1:0] o_distance,
    output logic                        o_overflowed
);

    mdu_pkg::t_root_state               r_state;
    mdu_pkg::t_root_state               n_state;
    mdu_pkg::t_root_ctl                 ctl;

    mdu_pkg::t_sum                      r_sum;
    logic                               r_sat;
    mdu_pkg::t_order                    r_ord;
    mdu_pkg::t_sum                      r_root;
    logic [mdu_pkg::BIT_WIDTH-1:0]      r_bit;
    mdu_pkg::t_sum                      r_sq;
    logic [mdu_pkg::SUM_WIDTH+1:0]      r_pw;

    logic                               r_out_v;
    mdu_pkg::t_sum                      r_out_dist;
    logic                               r_out_ovf;

    logic                               out_free;
    logic [mdu_pkg::ROOT_WIDTH-1:0]     cand;
    mdu_pkg::t_sum                      cand_sq;
    logic [mdu_pkg::SUM_WIDTH+1:0]      cand_cube;
    mdu_pkg::t_sum                      cand_quartic;
    logic [mdu_pkg::SUM_WIDTH+1:0]      trial;

    assign out_free = !r_out_v || !i_stall;
    assign cand     = r_root[mdu_pkg::ROOT_WIDTH-1:0] | (mdu_pkg::ROOT_WIDTH'(1) << r_bit);

    assign cand_sq      = cand * cand;
    assign cand_cube    = r_sq[43:0] * cand[21:0];
    assign cand_quartic = r_sq[31:0] * r_sq[31:0];
    assign trial        = (r_ord == mdu_pkg::ORD_EUCLID) ? {2'b00, r_sq} : r_pw;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdu_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_job.ord == mdu_pkg::ORD_MANHATTAN) ?
                              mdu_pkg::ST_DONE : mdu_pkg::ST_SQUARE;
                end
            end
            mdu_pkg::ST_SQUARE: begin
                n_state = (r_ord == mdu_pkg::ORD_EUCLID) ? mdu_pkg::ST_TEST : mdu_pkg::ST_RAISE;
            end
            mdu_pkg::ST_RAISE: begin
                n_state = mdu_pkg::ST_TEST;
            end
            mdu_pkg::ST_TEST: begin
                n_state = (r_bit == '0) ? mdu_pkg::ST_DONE : mdu_pkg::ST_SQUARE;
            end
            mdu_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = mdu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mdu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctl = '0;
        case (r_state)
            mdu_pkg::ST_IDLE:   ctl.pop      = i_q_valid;
            mdu_pkg::ST_SQUARE: ctl.square   = 1'b1;
            mdu_pkg::ST_RAISE:  ctl.raise    = 1'b1;
            mdu_pkg::ST_TEST:   ctl.test     = 1'b1;
            mdu_pkg::ST_DONE:   ctl.load_out = out_free;
            default:            ctl          = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdu_pkg::ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load_out) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.pop) begin
            r_sum  <= i_job.sum;
            r_sat  <= i_job.sat;
            r_ord  <= i_job.ord;
            r_root <= (i_job.ord == mdu_pkg::ORD_MANHATTAN) ? i_job.sum : '0;
            r_bit  <= mdu_pkg::root_top(i_job.ord);
        end
        if (ctl.square) begin
            r_sq <= cand_sq;
        end
        if (ctl.raise) begin
            r_pw <= (r_ord == mdu_pkg::ORD_CUBIC) ? cand_cube : {2'b00, cand_quartic};
        end
        if (ctl.test) begin
            if (trial <= {2'b00, r_sum}) begin
                r_root[mdu_pkg::ROOT_WIDTH-1:0] <= cand;
            end
            r_bit <= r_bit - 1'b1;
        end
        if (ctl.load_out) begin
            r_out_dist <= r_root;
            r_out_ovf  <= r_sat;
        end
    end

    assign o_pop        = ctl.pop;
    assign o_valid      = r_out_v;
    assign o_distance   = r_out_dist;
    assign o_overflowed = r_out_ovf;

`ifndef ASSERT_OFF
    a_start_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdu_pkg::ST_IDLE && i_q_valid && i_job.ord != mdu_pkg::ORD_MANHATTAN)
        |=> (r_state == mdu_pkg::ST_SQUARE))
        else $error("root search did not start after taking a sum");
    a_root_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != mdu_pkg::ST_IDLE && r_ord != mdu_pkg::ORD_MANHATTAN)
        |-> (r_root[mdu_pkg::SUM_WIDTH-1:mdu_pkg::ROOT_WIDTH] == '0))
        else $error("root grew beyond its search range");
    a_euclid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mdu_pkg::ST_DONE && r_ord == mdu_pkg::ORD_EUCLID)
        |-> (mdu_pkg::t_sum'(r_root[31:0] * r_root[31:0]) <= r_sum))
        else $error("square root overshoots the sum");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> ($past(r_state) == mdu_pkg::ST_DONE))
        else $error("result appeared without a finished root");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the Minkowski distance unit, with an L-p distance predictor.
module tb;

    localparam int          CLK_HALF       = 6;
    localparam int unsigned TIMEOUT_CYCLES = 1000000;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned PHASES         = 10;
    localparam int unsigned PHASE_PAIRS    = 180;
    localparam int unsigned STEADY_PHASE   = 1;
    localparam int unsigned IDLE_PERCENT   = 38;

    localparam mdu_pkg::t_order ORD_UNDER     = 3'd0;
    localparam mdu_pkg::t_order ORD_OVER_FIVE = 3'd5;
    localparam mdu_pkg::t_order ORD_OVER_SIX  = 3'd6;
    localparam mdu_pkg::t_order ORD_OVER_TOP  = 3'd7;

    class lp_distance_book;
        typedef struct {
            mdu_pkg::t_sum distance;
            logic          overflowed;
        } t_expect;

        mdu_pkg::t_order order_reg;
        mdu_pkg::t_sum   power_sum;
        logic            saturated;
        t_expect         pending[$];
        int unsigned     faults;

        function new();
            order_reg = mdu_pkg::ORD_RESET;
            power_sum = '0;
            saturated = 1'b0;
            faults    = 0;
        endfunction

        function mdu_pkg::t_order active_order();
            if (order_reg < mdu_pkg::ORD_MANHATTAN) return mdu_pkg::ORD_MANHATTAN;
            if (order_reg > mdu_pkg::ORD_QUARTIC) return mdu_pkg::ORD_QUARTIC;
            return order_reg;
        endfunction

        function mdu_pkg::t_sum raise(logic [15:0] mag, mdu_pkg::t_order p);
            mdu_pkg::t_sum r;
            r = mdu_pkg::t_sum'(1);
            for (int unsigned k = 0; k < p; k++) r = r * mdu_pkg::t_sum'(mag);
            return r;
        endfunction

        function mdu_pkg::t_sum root_floor(mdu_pkg::t_sum s, mdu_pkg::t_order p);
            logic [63:0]  r;
            logic [63:0]  cand;
            logic [127:0] pw;
            if (p == mdu_pkg::ORD_MANHATTAN) return s;
            r = '0;
            for (int b = 31; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                pw = 128'd1;
                for (int unsigned k = 0; k < p; k++) pw = pw * {64'd0, cand};
                if (pw <= {64'd0, s}) r = cand;
            end
            return r;
        endfunction

        function void add_pair(logic [15:0] a, logic [15:0] b, logic last);
            int              sa;
            int              sb;
            int              diff;
            logic [15:0]     mag;
            mdu_pkg::t_order p;
            mdu_pkg::t_sum   term;
            logic [64:0]     total;
            t_expect         e;
            sa    = $signed(a);
            sb    = $signed(b);
            diff  = sa - sb;
            mag   = 16'(diff < 0 ? -diff : diff);
            p     = active_order();
            term  = raise(mag, p);
            total = {1'b0, power_sum} + {1'b0, term};
            if (total[64]) begin
                power_sum = '1;
                saturated = 1'b1;
            end else begin
                power_sum = total[63:0];
            end
            if (last) begin
                e.distance   = root_floor(power_sum, p);
                e.overflowed = saturated;
                pending.push_back(e);
                power_sum = '0;
                saturated = 1'b0;
            end
        endfunction

        function void match_result(mdu_pkg::t_sum got_distance, logic got_overflow);
            t_expect e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result: distance %0d overflowed %0b",
                         $time, got_distance, got_overflow);
                faults++;
                return;
            end
            e = pending.pop_front();
            if (got_distance !== e.distance) begin
                $display("%0t distance mismatch: expected %0d, actual %0d",
                         $time, e.distance, got_distance);
                faults++;
            end
            if (got_overflow !== e.overflowed) begin
                $display("%0t overflowed mismatch: expected %0b, actual %0b",
                         $time, e.overflowed, got_overflow);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_power_order_we = 1'b0;
    logic [2:0]  i_power_order    = mdu_pkg::ORD_RESET;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [15:0] i_first_element  = '0;
    logic [15:0] i_second_element = '0;
    logic        i_last_pair      = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic [63:0] o_distance;
    logic        o_overflowed;

    logic            steady = 1'b0;
    lp_distance_book book;
    mdu_pkg::t_order order_plan [8] = '{mdu_pkg::ORD_QUARTIC, mdu_pkg::ORD_MANHATTAN,
                                        ORD_UNDER, mdu_pkg::ORD_EUCLID,
                                        ORD_OVER_TOP, mdu_pkg::ORD_CUBIC,
                                        ORD_OVER_FIVE, ORD_OVER_SIX};

    minkowski_distance_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_power_order_we (i_power_order_we),
        .i_power_order    (i_power_order),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_first_element  (i_first_element),
        .i_second_element (i_second_element),
        .i_last_pair      (i_last_pair),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_distance       (o_distance),
        .o_overflowed     (o_overflowed)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            book.match_result(o_distance, o_overflowed);
        end
    end

    task automatic send_pair(logic [15:0] a, logic [15:0] b, logic last);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_element  <= a;
        i_second_element <= b;
        i_last_pair      <= last;
        @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        @(posedge i_clk);
        book.add_pair(a, b, last);
    endtask

    task automatic set_order(mdu_pkg::t_order value);
        i_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_power_order_we <= 1'b1;
        i_power_order    <= value;
        @(posedge i_clk);
        i_power_order_we <= 1'b0;
        book.order_reg = value;
    endtask

    function automatic logic [15:0] edge_value();
        case ($urandom_range(3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    task automatic random_vector(int unsigned len);
        logic [15:0] a;
        logic [15:0] b;
        int unsigned mode;
        for (int unsigned k = 0; k < len; k++) begin
            mode = $urandom_range(99);
            if (mode < 50) begin
                a = 16'($urandom);
                b = 16'($urandom);
            end else if (mode < 65) begin
                a = edge_value();
                b = edge_value();
            end else if (mode < 80) begin
                a = 16'(16'hfff0 + $urandom_range(31));
                b = 16'(16'hfff0 + $urandom_range(31));
            end else if (mode < 90) begin
                a = 16'($urandom);
                b = a;
            end else begin
                a = 16'(16'h7fff - $urandom_range(15));
                b = 16'(16'h8000 + $urandom_range(15));
                if ($urandom_range(1)) {a, b} = {b, a};
            end
            send_pair(a, b, k == len - 1);
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        book = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h7fff, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7fff, 1'b0);
        send_pair(16'd100, 16'hff9c, 1'b1);
        set_order(mdu_pkg::ORD_MANHATTAN);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7fff, 1'b1);
        set_order(mdu_pkg::ORD_QUARTIC);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'h7fff, 16'h8000, 1'b0);
        send_pair(16'd5, 16'd5, 1'b1);
        send_pair(16'd3, 16'd1, 1'b1);
        set_order(mdu_pkg::ORD_CUBIC);
        send_pair(16'hffff, 16'h0000, 1'b1);
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'd10, 16'd0, 1'b0);
        set_order(mdu_pkg::ORD_MANHATTAN);
        send_pair(16'd7, 16'd0, 1'b1);
        set_order(ORD_UNDER);
        send_pair(16'd1, 16'hffff, 1'b1);
        set_order(ORD_OVER_TOP);
        send_pair(16'd2, 16'd0, 1'b0);
        send_pair(16'd2, 16'd0, 1'b1);

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            set_order(ph < 8 ? order_plan[ph] : mdu_pkg::t_order'($urandom_range(7)));
            steady <= (ph == STEADY_PHASE);
            sent = 0;
            while (sent < PHASE_PAIRS) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                random_vector(len);
                sent += len;
            end
        end

        i_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.faults == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/mdu_pkg.sv
src/mdu_front.sv
src/mdu_queue.sv
src/mdu_root.sv
src/minkowski_distance_unit.sv
verif/tb.sv
